// ===== rtl/fpp_pkg.sv =====
// Package for the fixed-period pulse pacer: codes, reset values and the
// status word that passes from the step logic to the top level.
// No dependencies.
package fpp_pkg;

  // Default width of the internal time arithmetic.
  localparam int unsigned TIME_WIDTH_DEFAULT = 32;

  localparam int unsigned FIELD_WIDTH = 32;
  localparam int unsigned COUNT_WIDTH = 8;
  localparam int unsigned INDEX_WIDTH = 8;

  localparam logic [FIELD_WIDTH-1:0] TICKS_RESET      = 32'd100;
  localparam logic [COUNT_WIDTH-1:0] LATE_LIMIT_RESET = 8'd5;
  localparam logic [COUNT_WIDTH-1:0] LATE_SATURATE    = 8'hFF;

  typedef enum logic [INDEX_WIDTH-1:0] {
    CFG_TICKS_PER_PULSE = 8'd0,
    CFG_LATE_LIMIT      = 8'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OUTCOME_ON_TIME = 2'd0,
    OUTCOME_LATE    = 2'd1,
    OUTCOME_OVERRUN = 2'd2
  } outcome_t;

  typedef struct packed {
    outcome_t               outcome;
    logic                   overrun;
    logic [COUNT_WIDTH-1:0] late_count;
  } status_t;

endpackage

// ===== rtl/fpp_cfg.sv =====
// Configuration registers of the pulse pacer: period and late limit.
// Depends on fpp_pkg.
module fpp_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fpp_pkg::INDEX_WIDTH-1:0]  cfg_index,
  input  logic [fpp_pkg::FIELD_WIDTH-1:0]  cfg_data,
  output logic [fpp_pkg::FIELD_WIDTH-1:0]  ticks_per_pulse,
  output logic [fpp_pkg::COUNT_WIDTH-1:0]  late_limit
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_pulse <= fpp_pkg::TICKS_RESET;
      late_limit      <= fpp_pkg::LATE_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fpp_pkg::CFG_TICKS_PER_PULSE: ticks_per_pulse <= cfg_data;
        fpp_pkg::CFG_LATE_LIMIT:      late_limit <= cfg_data[fpp_pkg::COUNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/fpp_step.sv =====
// Step logic of the pulse pacer: elapsed time, on-time or late decision,
// the next mark and the next late count. Depends on fpp_pkg.
module fpp_step #(
  parameter int unsigned TIME_WIDTH = fpp_pkg::TIME_WIDTH_DEFAULT
) (
  input  logic [fpp_pkg::FIELD_WIDTH-1:0]  now_time,
  input  logic [TIME_WIDTH-1:0]            mark,
  input  logic [fpp_pkg::COUNT_WIDTH-1:0]  late_counter,
  input  logic [fpp_pkg::FIELD_WIDTH-1:0]  ticks_per_pulse,
  input  logic [fpp_pkg::COUNT_WIDTH-1:0]  late_limit,
  output logic [TIME_WIDTH-1:0]            mark_next,
  output logic [fpp_pkg::FIELD_WIDTH-1:0]  wait_ticks,
  output fpp_pkg::status_t                 status
);

  logic [TIME_WIDTH-1:0]           now_w;
  logic [TIME_WIDTH-1:0]           period;
  logic [TIME_WIDTH-1:0]           elapsed;
  logic [TIME_WIDTH-1:0]           wait_w;
  logic [TIME_WIDTH-1:0]           excess;
  logic [fpp_pkg::COUNT_WIDTH-1:0] late_inc;
  logic                            on_time;
  logic                            overrun;

  assign now_w    = TIME_WIDTH'(now_time);
  assign period   = TIME_WIDTH'(ticks_per_pulse);
  assign elapsed  = now_w - mark;
  assign on_time  = (elapsed <= period);
  assign wait_w   = period - elapsed;
  assign excess   = elapsed - period;
  assign late_inc = (late_counter == fpp_pkg::LATE_SATURATE) ? late_counter
                                                             : late_counter + 1'b1;
  // The doubled period is never formed, so it cannot wrap.
  assign overrun  = (late_inc > late_limit) || (excess > period);

  always_comb begin
    wait_ticks = '0;
    status     = '{outcome: fpp_pkg::OUTCOME_ON_TIME, overrun: 1'b0, late_count: '0};
    if (on_time) begin
      mark_next  = now_w + wait_w;
      wait_ticks = fpp_pkg::FIELD_WIDTH'(wait_w);
    end else if (overrun) begin
      mark_next         = now_w;
      status.outcome    = fpp_pkg::OUTCOME_OVERRUN;
      status.overrun    = 1'b1;
      status.late_count = late_inc;
    end else begin
      mark_next         = now_w - excess;
      status.outcome    = fpp_pkg::OUTCOME_LATE;
      status.late_count = late_inc;
    end
  end

endmodule

// ===== rtl/fixed_period_pulse_pacer.sv =====
// Top level of the fixed-period pulse pacer: input register, pacing state,
// result register. Depends on fpp_pkg, fpp_cfg and fpp_step.
//
// The pacer takes one time sample per cycle while the result side does not
// stall, and gives one result word for each: the sample is held in the input
// register and its word then in the result register. The figure of one word
// per cycle is set by the loop through the mark register: the subtract,
// compare and add that form the next mark are combinational. A finished word
// waits in the result register while the next sample is taken into the input
// register. Configuration writes are taken in any cycle and should be made only
// while no sample is in flight.
module fixed_period_pulse_pacer #(
  parameter int unsigned TIME_WIDTH = fpp_pkg::TIME_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fpp_pkg::INDEX_WIDTH-1:0]  cfg_index,
  input  logic [fpp_pkg::FIELD_WIDTH-1:0]  cfg_data,
  input  logic                             sample_valid,
  output logic                             sample_stall,
  input  logic [fpp_pkg::FIELD_WIDTH-1:0]  now_time,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [fpp_pkg::FIELD_WIDTH-1:0]  wait_ticks,
  output logic [fpp_pkg::FIELD_WIDTH-1:0]  pulse_number,
  output logic [1:0]                       outcome,
  output logic                             overrun_flag,
  output logic [fpp_pkg::COUNT_WIDTH-1:0]  late_count
);

  logic [fpp_pkg::FIELD_WIDTH-1:0] ticks_per_pulse;
  logic [fpp_pkg::COUNT_WIDTH-1:0] late_limit;

  logic                            hold_valid;
  logic [fpp_pkg::FIELD_WIDTH-1:0] hold_time;

  logic [TIME_WIDTH-1:0]           last_mark;
  logic [fpp_pkg::COUNT_WIDTH-1:0] late_counter;
  logic [fpp_pkg::FIELD_WIDTH-1:0] pulse_counter;

  logic [TIME_WIDTH-1:0]           last_mark_next;
  logic [fpp_pkg::FIELD_WIDTH-1:0] wait_next;
  fpp_pkg::status_t                status_next;
  logic [fpp_pkg::FIELD_WIDTH-1:0] pulse_counter_next;

  logic out_free;
  logic advance;
  logic take;

  fpp_cfg u_cfg (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .ticks_per_pulse (ticks_per_pulse),
    .late_limit      (late_limit)
  );

  fpp_step #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_step (
    .now_time        (hold_time),
    .mark            (last_mark),
    .late_counter    (late_counter),
    .ticks_per_pulse (ticks_per_pulse),
    .late_limit      (late_limit),
    .mark_next       (last_mark_next),
    .wait_ticks      (wait_next),
    .status          (status_next)
  );

  assign out_free           = !result_valid || !result_stall;
  assign advance            = hold_valid && out_free;
  assign sample_stall       = hold_valid && !out_free;
  assign take               = sample_valid && !sample_stall;
  assign pulse_counter_next = pulse_counter + 1'b1;

  // Input register: refilled in the same cycle that its word moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_time <= now_time;
    end
  end

  // Pacing state moves only when a word reaches the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_mark     <= '0;
      late_counter  <= '0;
      pulse_counter <= '0;
      overrun_flag  <= 1'b0;
    end else if (advance) begin
      last_mark     <= last_mark_next;
      late_counter  <= status_next.late_count;
      pulse_counter <= pulse_counter_next;
      overrun_flag  <= status_next.overrun;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      wait_ticks   <= wait_next;
      pulse_number <= pulse_counter_next;
      outcome      <= status_next.outcome;
    end
  end

  assign late_count = late_counter;

  a_pulse_matches_counter: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> pulse_number == pulse_counter)
    else $error("pulse number differs from the pulse counter");

  a_overrun_matches_outcome: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> overrun_flag == (outcome == fpp_pkg::OUTCOME_OVERRUN))
    else $error("overrun flag disagrees with the outcome");

  a_late_has_no_wait: assert property (@(posedge clk) disable iff (rst)
    result_valid && outcome != fpp_pkg::OUTCOME_ON_TIME |-> wait_ticks == '0 && late_count != '0)
    else $error("late word carries a wait or a zero late count");

  a_on_time_clears_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && outcome == fpp_pkg::OUTCOME_ON_TIME |-> late_count == '0)
    else $error("on-time word leaves a late count");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> hold_valid && result_valid)
    else $error("input stalled with room in the pipeline");

endmodule

// ===== tb/fixed_period_pulse_pacer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for fixed_period_pulse_pacer: a pacing tracker class predicts
// each result word, plain tasks drive the time samples and register writes.
// Depends on fpp_pkg and the pacer RTL.
module fixed_period_pulse_pacer_tb;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 80;

  typedef struct {
    logic [31:0]       remain;
    logic [31:0]       pulse;
    fpp_pkg::outcome_t outcome;
    logic              overrun;
    logic [7:0]        late;
  } pulse_result_t;

  class pulse_pacer_tracker;
    logic [31:0] period = fpp_pkg::TICKS_RESET;
    logic [7:0]  limit = fpp_pkg::LATE_LIMIT_RESET;
    logic [31:0] mark = '0;
    logic [7:0]  late_run = '0;
    logic [31:0] pulses = '0;
    logic        overrun = 1'b0;
    int unsigned faults = 0;
    pulse_result_t expected_pulses[$];

    function void write_reg(fpp_pkg::cfg_reg_t idx, logic [31:0] data);
      case (idx)
        fpp_pkg::CFG_TICKS_PER_PULSE: period = data;
        fpp_pkg::CFG_LATE_LIMIT:      limit = data[7:0];
        default: ;
      endcase
    endfunction

    // Works out the word that an accepted time sample must produce.
    function void note_sample(logic [31:0] now);
      logic [31:0] elapsed;
      logic [31:0] excess;
      pulse_result_t r;
      elapsed = now - mark;
      r.remain = '0;
      if (elapsed <= period) begin
        r.remain = period - elapsed;
        mark = now + r.remain;
        late_run = '0;
        overrun = 1'b0;
        r.outcome = fpp_pkg::OUTCOME_ON_TIME;
      end else begin
        excess = elapsed - period;
        if (late_run != fpp_pkg::LATE_SATURATE) late_run++;
        // Comparing the excess with the period avoids doubling the period.
        if (late_run > limit || excess > period) begin
          mark = now;
          overrun = 1'b1;
          r.outcome = fpp_pkg::OUTCOME_OVERRUN;
        end else begin
          mark = now - excess;
          overrun = 1'b0;
          r.outcome = fpp_pkg::OUTCOME_LATE;
        end
      end
      pulses++;
      r.pulse = pulses;
      r.overrun = overrun;
      r.late = late_run;
      expected_pulses.push_back(r);
    endfunction

    function void check_result(logic [31:0] w, logic [31:0] p, logic [1:0] oc,
                               logic ov, logic [7:0] lc);
      pulse_result_t r;
      if (expected_pulses.size() == 0) begin
        $error("result word with no pulse expected: pulse_number %0d", p);
        faults++;
        return;
      end
      r = expected_pulses.pop_front();
      if (w !== r.remain) begin
        $error("wait_ticks: expected %0d, got %0d", r.remain, w);
        faults++;
      end
      if (p !== r.pulse) begin
        $error("pulse_number: expected %0d, got %0d", r.pulse, p);
        faults++;
      end
      if (oc !== r.outcome) begin
        $error("outcome: expected %0d, got %0d", r.outcome, oc);
        faults++;
      end
      if (ov !== r.overrun) begin
        $error("overrun_flag: expected %0d, got %0d", r.overrun, ov);
        faults++;
      end
      if (lc !== r.late) begin
        $error("late_count: expected %0d, got %0d", r.late, lc);
        faults++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        sample_valid;
  logic        sample_stall;
  logic [31:0] now_time;
  logic        result_valid;
  logic        result_stall;
  logic [31:0] wait_ticks;
  logic [31:0] pulse_number;
  logic [1:0]  outcome;
  logic        overrun_flag;
  logic [7:0]  late_count;

  pulse_pacer_tracker pacer = new();
  bit quiet = 1'b0;
  bit hold_off = 1'b0;
  int unsigned idle_cycles = 0;

  fixed_period_pulse_pacer uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .now_time(now_time),
    .result_valid(result_valid), .result_stall(result_stall),
    .wait_ticks(wait_ticks), .pulse_number(pulse_number), .outcome(outcome),
    .overrun_flag(overrun_flag), .late_count(late_count)
  );

  always #1 clk = ~clk;

  // Receiver: random stalls, none while quiet, and one long hold-off on request.
  always begin
    @(posedge clk);
    if (hold_off) begin
      result_stall <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_off = 1'b0;
    end else begin
      result_stall <= !quiet && ($urandom_range(0, 99) < 11);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      pacer.check_result(wait_ticks, pulse_number, outcome, overrun_flag, late_count);
  end

  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Writes the period and then the late limit, keeping valid high between them.
  task automatic program_pacer(logic [31:0] ticks, logic [7:0] lim);
    cfg_valid <= 1'b1;
    cfg_index <= fpp_pkg::CFG_TICKS_PER_PULSE;
    cfg_data <= ticks;
    do @(posedge clk); while (!cfg_ready);
    pacer.write_reg(fpp_pkg::CFG_TICKS_PER_PULSE, ticks);
    cfg_index <= fpp_pkg::CFG_LATE_LIMIT;
    cfg_data <= {24'd0, lim};
    do @(posedge clk); while (!cfg_ready);
    pacer.write_reg(fpp_pkg::CFG_LATE_LIMIT, {24'd0, lim});
    cfg_valid <= 1'b0;
  endtask

  task automatic send_sample(logic [31:0] t);
    if (!quiet && $urandom_range(0, 99) < 11) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    now_time <= t;
    do @(posedge clk); while (sample_stall);
    pacer.note_sample(t);
  endtask

  // Waits for every outstanding word, then lets the pipeline settle.
  task automatic drain_results();
    sample_valid <= 1'b0;
    while (pacer.expected_pulses.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic run_phase(int unsigned n);
    int unsigned kind;
    logic [31:0] delta;
    repeat (n) begin
      kind = $urandom_range(0, 99);
      if (kind < 40)
        delta = $urandom_range(pacer.period, 0);
      else if (kind < 65)
        delta = pacer.period + ((pacer.period == 0) ? 32'd1 : $urandom_range(1, pacer.period));
      else if (kind < 75)
        delta = pacer.period + pacer.period + 1 + $urandom_range(0, 50);
      else if (kind < 85)
        case ($urandom_range(0, 3))
          0: delta = pacer.period;
          1: delta = pacer.period + 1;
          2: delta = pacer.period + pacer.period;
          default: delta = pacer.period + pacer.period + 1;
        endcase
      else
        delta = $urandom - pacer.mark;
      send_sample(pacer.mark + delta);
    end
  endtask

  function automatic logic [31:0] pick_period();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      3: return $urandom_range(1, 3);
      default: return $urandom_range(4, 2000);
    endcase
  endfunction

  function automatic logic [7:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      default: return $urandom_range(1, 20);
    endcase
  endfunction

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sample_valid = 1'b0;
    now_time = '0;
    result_stall = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: on time, exactly on the boundary, late, overrun, wrap of time.
    send_sample(32'd0);
    send_sample(32'd100);
    send_sample(pacer.mark + 101);
    send_sample(pacer.mark + 100);
    send_sample(pacer.mark + 201);
    send_sample(pacer.mark + 200);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'd0);
    send_sample(pacer.mark);
    // A run of slightly late pulses until the late count passes the limit.
    repeat (7) send_sample(pacer.mark + 110);
    drain_results();

    // Zero period: only an elapsed time of nothing is on time.
    program_pacer(32'd0, 8'd255);
    send_sample(pacer.mark);
    send_sample(pacer.mark + 1);
    send_sample(pacer.mark + 32'hFFFF_FFFF);
    drain_results();
    program_pacer(32'hFFFF_FFFF, 8'd0);
    send_sample(32'h1234_5678);
    send_sample(32'hFFFF_FFFF);
    drain_results();
    // A period above half the range must not be doubled with wrap.
    program_pacer(32'h9000_0000, 8'd255);
    send_sample(pacer.mark + 32'hFFFF_FFFF);
    drain_results();
    program_pacer(32'h8000_0000, 8'd0);
    send_sample(pacer.mark + 32'h8000_0001);
    drain_results();

    for (int ph = 0; ph < 7; ph++) begin
      program_pacer(pick_period(), pick_limit());
      quiet = (ph == 2);
      if (ph == 4) hold_off = 1'b1;
      run_phase(75);
      drain_results();
      quiet = 1'b0;
    end

    // Long late streak with the limit at its top, so the late count saturates.
    program_pacer($urandom_range(2, 500), 8'd255);
    repeat (270)
      send_sample(pacer.mark + pacer.period + $urandom_range(1, pacer.period));
    drain_results();

    repeat (10) @(posedge clk);
    if (pacer.faults == 0 && pacer.expected_pulses.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule
